>>> hdl/krr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krr_pkg: shared types and constants of the kinetic reaction rate block
// Configuration layout, queue entry, state encodings and the 2^(k/16) table.
// ----------------------------------------------------------------------------
package krr_pkg;

  localparam int NUM_SPECIES   = 7;
  localparam int NUM_REACTIONS = 2;
  localparam int RXN_W         = (NUM_REACTIONS > 1) ? $clog2(NUM_REACTIONS) : 1;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_W         = 32;

  // log10(2) in Q0.32, log2(10) in Q3.28, ln2 in Q0.16
  localparam logic [30:0] LOG10_OF_2 = 31'd1292913986;
  localparam logic [29:0] LOG2_OF_10 = 30'd891723284;
  localparam logic [15:0] LN2_Q16    = 16'd45426;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOICH_0 = 3'd0,
    REG_STOICH_1 = 3'd1,
    REG_LOGK_0   = 3'd2,
    REG_LOGK_1   = 3'd3,
    REG_RATEK_0  = 3'd4,
    REG_RATEK_1  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [1:0][20:0] stoich;
    logic [1:0][23:0] log_k;
    logic [1:0][31:0] rate_k;
  } cfg_t;

  // one finished species set handed from front to back
  typedef struct packed {
    logic [NUM_REACTIONS-1:0][31:0] acc;
    logic [31:0]                    area;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    F_IDLE, F_NORM, F_LOG, F_SCALE, F_ACC, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_POLY, B_SQ, B_MANT, B_P0, B_P1, B_FIN
  } back_state_t;

  // 2^(k/16) in Q1.16
  function automatic logic [16:0] pow2_frac(input logic [3:0] k);
    logic [16:0] v;
    case (k)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd68438;
      4'd2:    v = 17'd71468;
      4'd3:    v = 17'd74632;
      4'd4:    v = 17'd77936;
      4'd5:    v = 17'd81386;
      4'd6:    v = 17'd84990;
      4'd7:    v = 17'd88752;
      4'd8:    v = 17'd92682;
      4'd9:    v = 17'd96785;
      4'd10:   v = 17'd101070;
      4'd11:   v = 17'd105545;
      4'd12:   v = 17'd110218;
      4'd13:   v = 17'd115098;
      4'd14:   v = 17'd120194;
      default: v = 17'd125515;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/krr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krr_front: species intake and saturation index accumulation
// Takes one species item, forms log10(c) + log10(gamma) with an iterative
// squaring log2 unit, and adds it times each reaction's coefficient into that reaction's accumulator.
// ----------------------------------------------------------------------------
module krr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           in_concentration,
  input  logic signed [23:0]    in_log_activity_coeff,
  input  logic [31:0]           in_surface_area,
  input  logic                  in_last_species,
  input  krr_pkg::cfg_t         cfg,
  input  krr_pkg::q_stat_t      q_stat,
  output logic                  push,
  output krr_pkg::job_t         job
);

  localparam logic [30:0] LOG10_OF_2_EXT = krr_pkg::LOG10_OF_2;

  krr_pkg::front_state_t state_r, state_nxt;

  logic [31:0]        c_r;
  logic signed [23:0] g_r;
  logic [31:0]        area_r;
  logic               last_r;
  logic [31:0]        z_r, z_nxt;
  logic [4:0]         msb_r, msb_nxt;
  logic [3:0]         bit_r;
  logic [15:0]        frac_r, frac_nxt;
  logic signed [21:0] l10_r, l10_nxt;
  logic [2:0]         count_r;
  logic signed [31:0] acc_r   [krr_pkg::NUM_REACTIONS];
  logic signed [31:0] acc_nxt [krr_pkg::NUM_REACTIONS];

  logic               accept;
  logic [63:0]        sq;
  logic [32:0]        zs;
  logic signed [6:0]  expo;
  logic signed [22:0] l2;
  logic [21:0]        l2_mag;
  logic [52:0]        scaled;
  logic [20:0]        mag;
  logic signed [25:0] term;
  logic [2:0]         sel;

  assign accept = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      krr_pkg::F_IDLE:  if (in_valid) state_nxt = krr_pkg::F_NORM;
      krr_pkg::F_NORM:  state_nxt = krr_pkg::F_LOG;
      krr_pkg::F_LOG:   if (bit_r == 4'd0) state_nxt = krr_pkg::F_SCALE;
      krr_pkg::F_SCALE: state_nxt = krr_pkg::F_ACC;
      krr_pkg::F_ACC:   state_nxt = last_r ? krr_pkg::F_PUSH : krr_pkg::F_IDLE;
      krr_pkg::F_PUSH:  if (!q_stat.full) state_nxt = krr_pkg::F_IDLE;
      default:          state_nxt = krr_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = (state_r != krr_pkg::F_IDLE);
    push     = (state_r == krr_pkg::F_PUSH) && !q_stat.full;
  end

  // leading one and normalization
  always_comb begin
    msb_nxt = 5'd0;
    for (int i = 1; i < 32; i++) begin
      if (c_r[i]) msb_nxt = 5'(i);
    end
    z_nxt = c_r << (5'd31 - msb_nxt);
  end

  // one squaring step of the log2 fraction
  always_comb begin
    sq       = 64'(z_r) * 64'(z_r);
    zs       = sq[63:31];
    frac_nxt = frac_r;
    if (zs[32]) frac_nxt[bit_r] = 1'b1;
  end

  // log2 to log10, rounded on the magnitude
  always_comb begin
    expo    = $signed({2'b00, msb_r}) - 7'sd24;
    l2      = $signed({expo, frac_r});
    l2_mag  = l2[22] ? 22'(-l2) : 22'(l2);
    scaled  = 53'(l2_mag) * 53'(LOG10_OF_2_EXT) + 53'h80000000;
    mag     = scaled[52:32];
    l10_nxt = l2[22] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  // coefficient times term, clamped accumulate
  always_comb begin
    logic signed [2:0]  coef;
    logic signed [28:0] prod;
    logic signed [33:0] v;
    term = 26'(l10_r) + 26'(g_r);
    sel  = (count_r < 3'(krr_pkg::NUM_SPECIES)) ? count_r : 3'd0;
    for (int r = 0; r < krr_pkg::NUM_REACTIONS; r++) begin
      coef = $signed(cfg.stoich[r][3*sel +: 3]);
      prod = 29'(coef) * 29'(term);
      v    = 34'(acc_r[r]) + 34'(prod);
      if (v > 34'sh7FFFFFFF)           acc_nxt[r] = 32'sh7FFFFFFF;
      else if (v < -34'sh80000000)     acc_nxt[r] = 32'sh80000000;
      else                             acc_nxt[r] = v[31:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= krr_pkg::F_IDLE;
      count_r <= 3'd0;
      for (int r = 0; r < krr_pkg::NUM_REACTIONS; r++) acc_r[r] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == krr_pkg::F_ACC && count_r < 3'(krr_pkg::NUM_SPECIES)) begin
        count_r <= count_r + 3'd1;
        for (int r = 0; r < krr_pkg::NUM_REACTIONS; r++) acc_r[r] <= acc_nxt[r];
      end
      if (push) begin
        count_r <= 3'd0;
        for (int r = 0; r < krr_pkg::NUM_REACTIONS; r++) acc_r[r] <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      c_r    <= (in_concentration == 32'd0) ? 32'd1 : in_concentration;
      g_r    <= in_log_activity_coeff;
      area_r <= in_surface_area;
      last_r <= in_last_species;
    end
    case (state_r)
      krr_pkg::F_NORM: begin
        msb_r  <= msb_nxt;
        z_r    <= z_nxt;
        bit_r  <= 4'd15;
        frac_r <= 16'd0;
      end
      krr_pkg::F_LOG: begin
        z_r    <= zs[32] ? zs[32:1] : zs[31:0];
        frac_r <= frac_nxt;
        bit_r  <= bit_r - 4'd1;
      end
      krr_pkg::F_SCALE: l10_r <= l10_nxt;
      default: ;
    endcase
  end

  always_comb begin
    for (int r = 0; r < krr_pkg::NUM_REACTIONS; r++) job.acc[r] = acc_r[r];
    job.area = area_r;
  end

endmodule

>>> hdl/krr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krr_queue: two-entry queue between intake and rate evaluation
// Holds finished species sets so the front can start the next set.
// ----------------------------------------------------------------------------
module krr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  krr_pkg::job_t     job_in,
  input  logic              pop,
  output krr_pkg::job_t     head,
  output krr_pkg::q_stat_t  stat
);

  krr_pkg::job_t mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      fill_r <= fill_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= job_in;
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (fill_r == 2'd2);
  assign stat.empty = (fill_r == 2'd0);

endmodule

>>> hdl/krr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krr_back: rate law evaluation per reaction
// For each reaction: 10^SI by a 2^x table and polynomial, then
// rate = area*k - area*k*10^SI, saturated, into the output register.
// ----------------------------------------------------------------------------
module krr_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  krr_pkg::job_t         head,
  input  krr_pkg::q_stat_t      q_stat,
  output logic                  pop,
  input  krr_pkg::cfg_t         cfg,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_reaction_index,
  output logic signed [31:0]    out_rate,
  output logic                  out_saturated,
  output logic                  out_last_rate
);

  krr_pkg::back_state_t state_r, state_nxt;

  krr_pkg::job_t             job_r;
  logic [krr_pkg::RXN_W-1:0] rxn_r;
  logic signed [63:0]        y_r;
  logic [63:0]               a_r;
  logic [15:0]               u_r;
  logic signed [19:0]        n_r;
  logic [3:0]                idx_r;
  logic [20:0]               poly_r;
  logic [17:0]               m_r;
  logic [49:0]               p0_r;
  logic [81:0]               prod_r;

  logic                      out_valid_r;
  logic                      out_idx_r, out_sat_r, out_last_r;
  logic signed [31:0]        out_rate_r;

  logic               load;
  logic               last_rxn;
  logic signed [63:0] si64;
  logic [31:0]        ru;
  logic [31:0]        uu;
  logic [37:0]        tp;
  logic               huge, big;
  logic [105:0]       sh;
  logic signed [20:0] s_amt;
  logic signed [41:0] diff;
  logic signed [31:0] rate_v;
  logic               sat_v;

  assign last_rxn = (rxn_r == krr_pkg::RXN_W'(krr_pkg::NUM_REACTIONS - 1));
  assign load     = (state_r == krr_pkg::B_FIN) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      krr_pkg::B_IDLE: if (!q_stat.empty) state_nxt = krr_pkg::B_MUL;
      krr_pkg::B_MUL:  state_nxt = krr_pkg::B_POLY;
      krr_pkg::B_POLY: state_nxt = krr_pkg::B_SQ;
      krr_pkg::B_SQ:   state_nxt = krr_pkg::B_MANT;
      krr_pkg::B_MANT: state_nxt = krr_pkg::B_P0;
      krr_pkg::B_P0:   state_nxt = krr_pkg::B_P1;
      krr_pkg::B_P1:   state_nxt = krr_pkg::B_FIN;
      krr_pkg::B_FIN:  if (load) state_nxt = last_rxn ? krr_pkg::B_IDLE : krr_pkg::B_MUL;
      default:         state_nxt = krr_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop = (state_r == krr_pkg::B_IDLE) && !q_stat.empty;
  end

  // arithmetic steps
  always_comb begin
    si64 = 64'($signed(job_r.acc[rxn_r])) - 64'($signed(cfg.log_k[rxn_r]));
    ru   = 32'(y_r[39:24]) * 32'(krr_pkg::LN2_Q16);
    uu   = 32'(u_r) * 32'(u_r);
    tp   = 38'(krr_pkg::pow2_frac(idx_r)) * 38'(poly_r);
  end

  // scale by 2^n, compare, subtract and clamp
  always_comb begin
    huge  = (n_r > 20'sd63);
    s_amt = 21'sd40 - 21'(n_r);
    if (n_r >= 20'sd40)     sh = 106'(prod_r) << 5'(n_r - 20'sd40);
    else if (s_amt >= 21'sd82) sh = '0;
    else                    sh = 106'(prod_r) >> 7'(s_amt);
    big  = |sh[105:41];
    diff = $signed({2'b00, a_r[63:24]}) - $signed({1'b0, sh[40:0]});
    sat_v = 1'b1;
    if (huge)                          rate_v = (a_r == 64'd0) ? 32'sd0 : 32'sh80000000;
    else if (big)                      rate_v = 32'sh80000000;
    else if (diff > 42'sh7FFFFFFF)     rate_v = 32'sh7FFFFFFF;
    else if (diff < -42'sh80000000)    rate_v = 32'sh80000000;
    else begin
      rate_v = diff[31:0];
      sat_v  = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= krr_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      rxn_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (pop) rxn_r <= '0;
      else if (load && !last_rxn) rxn_r <= rxn_r + 1'b1;
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) job_r <= head;
    case (state_r)
      krr_pkg::B_MUL: begin
        y_r <= si64 * 64'(krr_pkg::LOG2_OF_10);
        a_r <= 64'(job_r.area) * 64'(cfg.rate_k[rxn_r]);
      end
      krr_pkg::B_POLY: begin
        u_r   <= ru[31:16];
        n_r   <= y_r[63:44];
        idx_r <= y_r[43:40];
      end
      krr_pkg::B_SQ:   poly_r <= 21'h100000 + 21'(u_r) + 21'(uu[31:21]);
      krr_pkg::B_MANT: m_r <= tp[37:20];
      krr_pkg::B_P0:   p0_r <= 50'(a_r[31:0]) * 50'(m_r);
      krr_pkg::B_P1:   prod_r <= 82'(p0_r) + (82'(50'(a_r[63:32]) * 50'(m_r)) << 32);
      default: ;
    endcase
    if (load) begin
      out_idx_r  <= 1'(rxn_r);
      out_rate_r <= rate_v;
      out_sat_r  <= sat_v;
      out_last_r <= last_rxn;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_reaction_index = out_idx_r;
  assign out_rate           = out_rate_r;
  assign out_saturated      = out_sat_r;
  assign out_last_rate      = out_last_r;

endmodule

>>> hdl/kinetic_reaction_rate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kinetic_reaction_rate: mineral reaction rates from species activities
// Accumulates saturation indices over a species set and emits one saturated
// rate per reaction after the last species.
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  input   | in_valid/in_stall, species fields          | in
//  output  | out_valid/out_stall, rate fields           | out
//  config  | cfg_we, cfg_index, cfg_data                | in
//
// The front takes one species item at a time and stalls the input until it
// is done: normalize, 16 log2 squaring steps, log10 scale, accumulate, and
// on the last item a queue push once there is room. The back pops a set from
// the two-entry queue and runs each reaction through its multiplier
// sequence; the queue lets the next set enter while rates are still computed.
// Reset is synchronous and clears accumulators, counters and queue; the
// output register holds its item while out_stall is high.
// ----------------------------------------------------------------------------
module kinetic_reaction_rate (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    in_concentration,
  input  logic signed [23:0]             in_log_activity_coeff,
  input  logic [31:0]                    in_surface_area,
  input  logic                           in_last_species,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_reaction_index,
  output logic signed [31:0]             out_rate,
  output logic                           out_saturated,
  output logic                           out_last_rate,
  input  logic                           cfg_we,
  input  logic [krr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [krr_pkg::CFG_W-1:0]      cfg_data
);

  krr_pkg::cfg_t    cfg_r;
  krr_pkg::job_t    push_job, head_job;
  krr_pkg::q_stat_t q_stat;
  logic             push, pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stoich[0] <= 21'd70;
      cfg_r.stoich[1] <= 21'd79;
      cfg_r.log_k[0]  <= 24'd1323172;
      cfg_r.log_k[1]  <= 24'd86508;
      cfg_r.rate_k[0] <= 32'd16693330;
      cfg_r.rate_k[1] <= 32'd166933;
    end else if (cfg_we) begin
      case (cfg_index)
        krr_pkg::REG_STOICH_0: cfg_r.stoich[0] <= cfg_data[20:0];
        krr_pkg::REG_STOICH_1: cfg_r.stoich[1] <= cfg_data[20:0];
        krr_pkg::REG_LOGK_0:   cfg_r.log_k[0]  <= cfg_data[23:0];
        krr_pkg::REG_LOGK_1:   cfg_r.log_k[1]  <= cfg_data[23:0];
        krr_pkg::REG_RATEK_0:  cfg_r.rate_k[0] <= cfg_data;
        krr_pkg::REG_RATEK_1:  cfg_r.rate_k[1] <= cfg_data;
        default: ;
      endcase
    end
  end

  krr_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_concentration      (in_concentration),
    .in_log_activity_coeff (in_log_activity_coeff),
    .in_surface_area       (in_surface_area),
    .in_last_species       (in_last_species),
    .cfg                   (cfg_r),
    .q_stat                (q_stat),
    .push                  (push),
    .job                   (push_job)
  );

  krr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .job_in (push_job),
    .pop    (pop),
    .head   (head_job),
    .stat   (q_stat)
  );

  krr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head_job),
    .q_stat             (q_stat),
    .pop                (pop),
    .cfg                (cfg_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_reaction_index (out_reaction_index),
    .out_rate           (out_rate),
    .out_saturated      (out_saturated),
    .out_last_rate      (out_last_rate)
  );

  // a set is never pushed into a full queue, never popped from an empty one
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("queue push while full");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  // an accepted item keeps the front busy on the next cycle
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("front took a second item");

  // the last-rate flag goes with the final reaction index
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_rate) |->
      (out_reaction_index == 1'(krr_pkg::NUM_REACTIONS - 1)))
    else $error("last rate on wrong reaction");

endmodule

>>> test/krr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krr_checker: rate predictor and scoreboard for kinetic_reaction_rate
// Watches the species, rate and register ports, computes the expected rates
// of every finished species set and compares each accepted rate field by field.
// ----------------------------------------------------------------------------
module krr_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [31:0]        in_concentration,
  input  logic signed [23:0] in_log_activity_coeff,
  input  logic [31:0]        in_surface_area,
  input  logic               in_last_species,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_reaction_index,
  input  logic signed [31:0] out_rate,
  input  logic               out_saturated,
  input  logic               out_last_rate,
  input  logic               cfg_we,
  input  logic [krr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [krr_pkg::CFG_W-1:0]     cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 rates_seen,
  output int                 sat_seen
);

  typedef struct packed {
    logic        rxn;
    logic [31:0] rate;
    logic        sat;
    logic        last;
  } rate_item_t;

  rate_item_t expected_rates[$];

  logic [20:0] row_q [2];
  logic [23:0] logk_q [2];
  logic [31:0] ratek_q [2];
  int unsigned species_seen;
  longint      si_acc [2];

  localparam longint ONE_Q44 = 64'sd17592186044416;

  // 2^(k/16), Q1.16
  function automatic longint unsigned pow2_sixteenth(input int k);
    case (k)
      0: return 65536;   1: return 68438;   2: return 71468;   3: return 74632;
      4: return 77936;   5: return 81386;   6: return 84990;   7: return 88752;
      8: return 92682;   9: return 96785;  10: return 101070; 11: return 105545;
      12: return 110218; 13: return 115098; 14: return 120194; default: return 125515;
    endcase
  endfunction

  // log10 of nonzero Q8.24, Q.16 result
  function automatic longint log10_conc(input logic [31:0] c);
    int          msb;
    logic [63:0] z;
    logic [15:0] frac;
    longint      l2;
    logic [63:0] mag;
    msb = 31;
    while (msb > 0 && c[msb] == 1'b0) msb--;
    z = 64'(c) << (31 - msb);
    frac = '0;
    for (int b = 15; b >= 0; b--) begin
      z = (z * z) >> 31;
      if (z >= 64'h1_0000_0000) begin
        frac[b] = 1'b1;
        z = z >> 1;
      end
    end
    l2 = longint'(msb - 24) * 65536 + longint'(frac);
    if (l2 >= 0) begin
      mag = (64'(l2) * 64'd1292913986 + 64'h8000_0000) >> 32;
      return longint'(mag);
    end
    mag = (64'(-l2) * 64'd1292913986 + 64'h8000_0000) >> 32;
    return -longint'(mag);
  endfunction

  // area*(1-10^si)*k, Q16.16 with clamps
  function automatic void predict_rate(input longint si, input logic [31:0] area,
                                       input logic [31:0] k, output logic [31:0] rate,
                                       output logic sat);
    logic [63:0]  a;
    longint       y, n, f, diff;
    logic [63:0]  f20, r, u, poly, m;
    logic [127:0] prod;
    a = 64'(area) * 64'(k);
    y = si * 64'sd891723284;
    sat = 1'b0;
    if (y >= 0) n = y / ONE_Q44;
    else n = -((-y + ONE_Q44 - 1) / ONE_Q44);
    if (n >= 64) begin
      sat = 1'b1;
      rate = (a == 0) ? 32'd0 : 32'h8000_0000;
      return;
    end
    f = y - n * ONE_Q44;
    f20 = 64'(f) >> 24;
    r = f20 & 64'hFFFF;
    u = (r * 64'd45426) >> 16;
    poly = (64'd1 << 20) + u + ((u * u) >> 21);
    m = (pow2_sixteenth(int'((f20 >> 16) & 64'hF)) * poly) >> 20;
    prod = 128'(a) * 128'(m);
    if (n >= 40) prod = prod << (n - 40);
    else if (40 - n >= 128) prod = '0;
    else prod = prod >> (40 - n);
    if (prod >= (128'd1 << 41)) begin
      sat = 1'b1;
      rate = 32'h8000_0000;
      return;
    end
    diff = longint'(a >> 24) - longint'(prod[63:0]);
    if (diff > 64'sd2147483647) begin
      sat = 1'b1; rate = 32'h7FFF_FFFF;
    end else if (diff < -64'sd2147483648) begin
      sat = 1'b1; rate = 32'h8000_0000;
    end else begin
      rate = diff[31:0];
    end
  endfunction

  assign pending = expected_rates.size();

  always @(posedge clk) begin
    longint     term;
    longint     coef, v;
    logic [31:0] rv;
    logic       sv;
    rate_item_t got, exp_item;
    if (!rst_n) begin
      row_q[0] <= 21'd70;        row_q[1] <= 21'd79;
      logk_q[0] <= 24'd1323172;  logk_q[1] <= 24'd86508;
      ratek_q[0] <= 32'd16693330; ratek_q[1] <= 32'd166933;
      species_seen = 0;
      si_acc[0] = 0; si_acc[1] = 0;
      expected_rates.delete();
      fail_count <= 0;
      rates_seen <= 0;
      sat_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (krr_pkg::reg_idx_t'(cfg_index))
          krr_pkg::REG_STOICH_0: row_q[0] <= cfg_data[20:0];
          krr_pkg::REG_STOICH_1: row_q[1] <= cfg_data[20:0];
          krr_pkg::REG_LOGK_0:   logk_q[0] <= cfg_data[23:0];
          krr_pkg::REG_LOGK_1:   logk_q[1] <= cfg_data[23:0];
          krr_pkg::REG_RATEK_0:  ratek_q[0] <= cfg_data;
          krr_pkg::REG_RATEK_1:  ratek_q[1] <= cfg_data;
          default: ;
        endcase
      end
      // species item: accumulate, emit expectations on last
      if (in_valid && !in_stall) begin
        term = log10_conc((in_concentration == 0) ? 32'd1 : in_concentration)
               + longint'(in_log_activity_coeff);
        if (species_seen < krr_pkg::NUM_SPECIES) begin
          for (int rx = 0; rx < krr_pkg::NUM_REACTIONS; rx++) begin
            coef = longint'($signed(row_q[rx][3*species_seen +: 3]));
            v = si_acc[rx] + coef * term;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            si_acc[rx] = v;
          end
          species_seen++;
        end
        if (in_last_species) begin
          for (int rx = 0; rx < krr_pkg::NUM_REACTIONS; rx++) begin
            predict_rate(si_acc[rx] - longint'($signed(logk_q[rx])), in_surface_area,
                         ratek_q[rx], rv, sv);
            expected_rates.push_back('{rxn: 1'(rx), rate: rv, sat: sv,
                                       last: (rx == krr_pkg::NUM_REACTIONS - 1)});
            si_acc[rx] = 0;
          end
          species_seen = 0;
        end
      end
      // rate item: compare against oldest expectation
      if (out_valid && !out_stall) begin
        got = '{rxn: out_reaction_index, rate: out_rate, sat: out_saturated,
                last: out_last_rate};
        rates_seen <= rates_seen + 1;
        if (out_saturated) sat_seen <= sat_seen + 1;
        if (expected_rates.size() == 0) begin
          $error("unexpected rate item: rate %0d", $signed(out_rate));
          fail_count <= fail_count + 1;
        end else begin
          exp_item = expected_rates.pop_front();
          if (got != exp_item) fail_count <= fail_count + 1;
          if (got.rxn != exp_item.rxn)
            $error("reaction_index: expected %0d, got %0d", exp_item.rxn, got.rxn);
          if (got.rate != exp_item.rate)
            $error("rate: expected %0d, got %0d", $signed(exp_item.rate),
                   $signed(got.rate));
          if (got.sat != exp_item.sat)
            $error("saturated: expected %0d, got %0d", exp_item.sat, got.sat);
          if (got.last != exp_item.last)
            $error("last_rate: expected %0d, got %0d", exp_item.last, got.last);
        end
      end
    end
  end

endmodule

>>> test/tb_kinetic_reaction_rate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kinetic_reaction_rate: randomized regression of the reaction rate block
// Sends directed and random species sets under bursty input and a stalling
// receiver, reprograms the registers between phases and lets krr_checker
// score every rate.
// ----------------------------------------------------------------------------
module tb_kinetic_reaction_rate;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        in_concentration = '0;
  logic signed [23:0] in_log_activity_coeff = '0;
  logic [31:0]        in_surface_area = '0;
  logic               in_last_species = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_reaction_index;
  logic signed [31:0] out_rate;
  logic               out_saturated;
  logic               out_last_rate;
  logic               cfg_we = 1'b0;
  logic [krr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [krr_pkg::CFG_W-1:0]     cfg_data = '0;
  int                 fail_count, pending, rates_seen, sat_seen;
  int                 items_sent = 0;
  int                 stall_mode = 0;
  int                 burst_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  kinetic_reaction_rate i_dut (.*);

  krr_checker i_checker (.*);

  // receiver stall pattern: free-running, steady, or heavy
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic write_reg(input krr_pkg::reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drops valid, then waits out all rates plus slack before reprogramming
  task automatic drain_rates();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // one species item; valid stays high within a burst, drops for a gap
  task automatic send_species(input logic [31:0] conc, input logic [23:0] lg,
                              input logic [31:0] area, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_concentration <= conc;
    in_log_activity_coeff <= lg;
    in_surface_area <= area;
    in_last_species <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  function automatic logic [31:0] rand_conc();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'(1) << $urandom_range(0, 31);
      3: return $urandom_range(32'h0080_0000, 32'h0200_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [23:0] rand_gamma();
    case ($urandom_range(0, 4))
      0: return 24'h80_0000;
      1: return 24'h7F_FFFF;
      2: return 24'($signed($urandom_range(0, 131072)) - 65536);
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] rand_area();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 32'h0010_0000);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_set(input int n);
    for (int s = 0; s < n; s++)
      send_species(rand_conc(), rand_gamma(), rand_area(), s == n - 1);
  endtask

  task automatic program_all(input logic [20:0] r0, input logic [20:0] r1,
                             input logic [23:0] k0, input logic [23:0] k1,
                             input logic [31:0] q0, input logic [31:0] q1);
    write_reg(krr_pkg::REG_STOICH_0, 32'(r0));
    write_reg(krr_pkg::REG_STOICH_1, 32'(r1));
    write_reg(krr_pkg::REG_LOGK_0, 32'(k0));
    write_reg(krr_pkg::REG_LOGK_1, 32'(k1));
    write_reg(krr_pkg::REG_RATEK_0, q0);
    write_reg(krr_pkg::REG_RATEK_1, q1);
  endtask

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset registers, extreme fields, short and overlong sets
    send_species(32'd0, 24'h80_0000, 32'd0, 1'b0);
    send_species(32'hFFFF_FFFF, 24'h7F_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_species(32'h0100_0000, 24'd0, 32'h0001_0000, 1'b1);
    for (int s = 0; s < 9; s++)
      send_species(32'hFFFF_FFFF, 24'h7F_FFFF, 32'hFFFF_FFFF, s == 8);
    for (int s = 0; s < 7; s++)
      send_species(32'd0, 24'h80_0000, 32'hFFFF_FFFF, s == 6);
    drain_rates();
    // huge positive and tiny saturation indices, maximum k
    program_all(21'h1FFFFF ^ 21'h0DB6DB, 21'h0DB6DB, 24'h80_0000, 24'h7F_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_set(7);
    send_set(3);
    drain_rates();
    program_all(21'd0, 21'h1FFFFF, 24'd0, 24'h80_0000, 32'd0, 32'h0100_0000);
    send_set(7);
    drain_rates();

    // random phases with fresh register settings
    for (int ph = 0; ph < 8; ph++) begin
      program_all(21'($urandom()), 21'($urandom()), 24'($urandom()), 24'($urandom()),
                  $urandom(), (ph == 3) ? 32'hFFFF_FFFF : $urandom());
      for (int st = 0; st < 15; st++)
        send_set(($urandom_range(0, 9) < 8) ? 7 : $urandom_range(1, 10));
      drain_rates();
    end
    program_all(21'd70, 21'd79, 24'd1323172, 24'd86508, 32'd16693330, 32'd166933);
    for (int st = 0; st < 10; st++) send_set(7);
    drain_rates();

    $display("sent %0d species items, checked %0d rates (%0d saturated)",
             items_sent, rates_seen, sat_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/krr_pkg.sv
hdl/krr_front.sv
hdl/krr_queue.sv
hdl/krr_back.sv
hdl/kinetic_reaction_rate.sv
test/krr_checker.sv
test/tb_kinetic_reaction_rate.sv
